>>> src/cts_pkg.sv
// shared types, token codes and keyword lookup for the c-subset token scanner
// no dependencies; imported by every module of the scanner
package cts_pkg;

  localparam int unsigned PositionWidthDefault = 16;
  localparam int unsigned LengthWidthDefault   = 8;
  localparam int unsigned QueueDepthDefault    = 2;

  localparam logic [7:0] CharNewline    = 8'd10;
  localparam logic [7:0] CharUnderscore = "_";
  localparam logic [7:0] CharPoint      = ".";
  localparam logic [7:0] CharEqual      = "=";

  typedef enum logic [4:0] {
    TK_INT      = 5'd0,
    TK_FLOAT    = 5'd1,
    TK_VOID     = 5'd2,
    TK_IF       = 5'd3,
    TK_ELSE     = 5'd4,
    TK_WHILE    = 5'd5,
    TK_RETURN   = 5'd6,
    TK_ID       = 5'd7,
    TK_INTNUM   = 5'd8,
    TK_FLOATNUM = 5'd9,
    TK_ADD      = 5'd10,
    TK_MUL      = 5'd11,
    TK_ASG      = 5'd12,
    TK_RELOP    = 5'd13,
    TK_SEMI     = 5'd14,
    TK_COMMA    = 5'd15,
    TK_LPAR     = 5'd16,
    TK_RPAR     = 5'd17,
    TK_LBR      = 5'd18,
    TK_RBR      = 5'd19,
    TK_LBRACK   = 5'd20,
    TK_RBRACK   = 5'd21,
    TK_EOF      = 5'd22,
    TK_UNKNOWN  = 5'd23
  } token_kind_e;

  // character classes as seen by the scanner
  typedef enum logic [2:0] {
    CC_SPACE  = 3'd0,
    CC_ALPHA  = 3'd1,  // letters and underscore
    CC_DIGIT  = 3'd2,
    CC_POINT  = 3'd3,
    CC_EQ     = 3'd4,
    CC_REL    = 3'd5,
    CC_PUNCT  = 3'd6,
    CC_OTHER  = 3'd7
  } char_class_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } cts_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  lexeme_length;
    logic [7:0]  first_char;
    logic        last;
  } cts_out_t;

  // classified transaction queued between front and back
  typedef struct packed {
    logic [7:0]  char_byte;
    logic        end_of_input;
    char_class_e cls;
    token_kind_e single_kind;
  } cts_entry_t;

  typedef struct packed {
    logic hold_valid;
    logic item_taken;
  } cts_back_stat_t;

  // prefix holds the lowest character in the low byte; len is 7 when over six
  function automatic token_kind_e kw_kind(input logic [47:0] prefix, input logic [2:0] len);
    token_kind_e kind;
    kind = TK_ID;
    unique case (len)
      3'd2: if (prefix[15:0] == "fi") kind = TK_IF;
      3'd3: if (prefix[23:0] == "tni") kind = TK_INT;
      3'd4: begin
        if (prefix[31:0] == "diov") kind = TK_VOID;
        else if (prefix[31:0] == "esle") kind = TK_ELSE;
      end
      3'd5: begin
        if (prefix[39:0] == "taolf") kind = TK_FLOAT;
        else if (prefix[39:0] == "elihw") kind = TK_WHILE;
      end
      3'd6: if (prefix[47:0] == "nruter") kind = TK_RETURN;
      default: kind = TK_ID;
    endcase
    return kind;
  endfunction

endpackage

>>> src/cts_front.sv
// front end: accepts characters and classifies them for the back end
// depends on cts_pkg
module cts_front import cts_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cts_in_t    in_data_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cts_entry_t push_data_o
);

  char_class_e cls;
  token_kind_e single_kind;
  logic [7:0]  c;

  assign c = in_data_i.char_byte;

  always_comb begin
    single_kind = TK_UNKNOWN;
    if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      cls = CC_SPACE;
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CharUnderscore) begin
      cls = CC_ALPHA;
    end else if (c >= "0" && c <= "9") begin
      cls = CC_DIGIT;
    end else if (c == CharPoint) begin
      cls = CC_POINT;
    end else if (c == CharEqual) begin
      cls = CC_EQ;
    end else if (c == "<" || c == ">") begin
      cls = CC_REL;
    end else begin
      cls = CC_PUNCT;
      case (c)
        "+":     single_kind = TK_ADD;
        "*":     single_kind = TK_MUL;
        ";":     single_kind = TK_SEMI;
        ",":     single_kind = TK_COMMA;
        "(":     single_kind = TK_LPAR;
        ")":     single_kind = TK_RPAR;
        "{":     single_kind = TK_LBR;
        "}":     single_kind = TK_RBR;
        "[":     single_kind = TK_LBRACK;
        "]":     single_kind = TK_RBRACK;
        default: begin
          cls         = CC_OTHER;
          single_kind = TK_UNKNOWN;
        end
      endcase
    end
  end

  assign push_valid_o             = in_valid_i;
  assign in_ready_o               = push_ready_i;
  assign push_data_o.char_byte    = c;
  assign push_data_o.end_of_input = in_data_i.end_of_input;
  assign push_data_o.cls          = cls;
  assign push_data_o.single_kind  = single_kind;

endmodule

>>> src/cts_queue.sv
// small fifo of classified transactions between front and back end
// depends on cts_pkg
module cts_queue import cts_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  cts_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output cts_entry_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cts_entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/cts_back.sv
// back end: scanner state machine, token assembly and output register with hold slot
// depends on cts_pkg
module cts_back import cts_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault,
  parameter int unsigned LENGTH_WIDTH   = LengthWidthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  cts_entry_t     pop_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cts_out_t       out_data_o,
  output cts_back_stat_t stat_o
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned LW = LENGTH_WIDTH;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_IDENT  = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_ASSIGN = 5'b01000,
    MODE_REL    = 5'b10000
  } scan_mode_e;

  scan_mode_e      mode_q, mode_d;
  logic            seen_q, seen_d;
  logic [PW-1:0]   tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [PW-1:0]   cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [LW-1:0]   tok_len_q, tok_len_d;
  logic [47:0]     prefix_q, prefix_d;
  logic [7:0]      pend_q, pend_d;

  logic            out_valid_q, hold_valid_q;
  cts_out_t        out_q, hold_q;

  logic            adv, fire;
  logic            flush_v, sec_v, flush_go, ext_any;
  cts_out_t        flush_r, sec_r, first_r;
  token_kind_e     flush_kind;
  logic [PW-1:0]   mv_line, mv_col;
  logic [LW-1:0]   len_inc;
  logic [47:0]     prefix_ext;
  logic [2:0]      kw_len;
  logic            ext_ident, ext_num, ext_rel;
  logic [7:0]      c;

  function automatic cts_out_t make_res(input token_kind_e kind, input logic [PW-1:0] line,
                                        input logic [PW-1:0] col, input logic [LW-1:0] len,
                                        input logic [7:0] fc);
    cts_out_t r;
    r.token_kind    = kind;
    r.start_line    = 16'(line);
    r.start_column  = 16'(col);
    r.lexeme_length = 8'(len);
    r.first_char    = fc;
    r.last          = 1'b1;
    return r;
  endfunction

  assign c       = pop_data_i.char_byte;
  assign adv     = !out_valid_q || out_ready_i;
  assign pop_ready_o = adv && !hold_valid_q;
  assign fire    = pop_valid_i && pop_ready_o;
  assign len_inc = (&tok_len_q) ? tok_len_q : tok_len_q + 1'b1;
  assign kw_len  = (tok_len_q <= LW'(6)) ? tok_len_q[2:0] : 3'd7;

  // saturating position advance for the current character
  always_comb begin
    if (c == CharNewline) begin
      mv_line = (&cur_line_q) ? cur_line_q : cur_line_q + 1'b1;
      mv_col  = PW'(1);
    end else begin
      mv_line = cur_line_q;
      mv_col  = (&cur_col_q) ? cur_col_q : cur_col_q + 1'b1;
    end
  end

  always_comb begin
    prefix_ext = prefix_q;
    for (int i = 0; i < 6; i++) begin
      if (tok_len_q == LW'(i)) prefix_ext[8*i +: 8] = c;
    end
  end

  always_comb begin
    flush_v    = 1'b1;
    flush_kind = TK_ID;
    unique case (mode_q)
      MODE_IDENT:  flush_kind = kw_kind(prefix_q, kw_len);
      MODE_NUMBER: flush_kind = seen_q ? TK_FLOATNUM : TK_INTNUM;
      MODE_ASSIGN: flush_kind = TK_ASG;
      MODE_REL:    flush_kind = TK_RELOP;
      default:     flush_v    = 1'b0;
    endcase
  end

  assign flush_r = make_res(flush_kind, tok_line_q, tok_col_q, tok_len_q, pend_q);

  assign ext_ident = (mode_q == MODE_IDENT) &&
                     (pop_data_i.cls == CC_ALPHA || pop_data_i.cls == CC_DIGIT);
  assign ext_num   = (mode_q == MODE_NUMBER) &&
                     (pop_data_i.cls == CC_DIGIT || (pop_data_i.cls == CC_POINT && !seen_q));
  assign ext_rel   = (mode_q == MODE_ASSIGN || mode_q == MODE_REL) &&
                     (pop_data_i.cls == CC_EQ);
  assign ext_any   = ext_ident || ext_num || ext_rel;

  // a pending token goes out when the character does not extend it or ends the input
  assign flush_go  = flush_v && (pop_data_i.end_of_input || !ext_any);

  always_comb begin
    first_r      = flush_r;
    first_r.last = !sec_v;
  end

  always_comb begin
    mode_d     = mode_q;
    seen_d     = seen_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    prefix_d   = prefix_q;
    pend_d     = pend_q;
    sec_v      = 1'b0;
    sec_r      = make_res(TK_EOF, cur_line_q, cur_col_q, '0, 8'd0);
    if (pop_data_i.end_of_input) begin
      // pending token, then eof, then back to the start of a new text
      sec_v      = 1'b1;
      mode_d     = MODE_IDLE;
      seen_d     = 1'b0;
      tok_line_d = PW'(1);
      tok_col_d  = PW'(1);
      tok_len_d  = '0;
      cur_line_d = PW'(1);
      cur_col_d  = PW'(1);
      prefix_d   = '0;
      pend_d     = '0;
    end else if (ext_any) begin
      prefix_d   = (tok_len_q < LW'(6)) ? prefix_ext : prefix_q;
      tok_len_d  = len_inc;
      cur_line_d = mv_line;
      cur_col_d  = mv_col;
      if (pop_data_i.cls == CC_POINT) seen_d = 1'b1;
      if (ext_rel) begin
        sec_v  = 1'b1;
        sec_r  = make_res(TK_RELOP, tok_line_q, tok_col_q, len_inc, pend_q);
        mode_d = MODE_IDLE;
      end
    end else begin
      mode_d     = MODE_IDLE;
      seen_d     = 1'b0;
      cur_line_d = mv_line;
      cur_col_d  = mv_col;
      case (pop_data_i.cls) inside
        CC_SPACE: ;
        CC_ALPHA, CC_DIGIT, CC_EQ, CC_REL: begin
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          tok_len_d  = LW'(1);
          prefix_d   = {40'd0, c};
          pend_d     = c;
          case (pop_data_i.cls)
            CC_ALPHA: mode_d = MODE_IDENT;
            CC_DIGIT: mode_d = MODE_NUMBER;
            CC_EQ:    mode_d = MODE_ASSIGN;
            default:  mode_d = MODE_REL;
          endcase
        end
        default: begin
          sec_v = 1'b1;
          sec_r = make_res(pop_data_i.single_kind, cur_line_q, cur_col_q, LW'(1), c);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      seen_q       <= 1'b0;
      tok_line_q   <= PW'(1);
      tok_col_q    <= PW'(1);
      tok_len_q    <= '0;
      cur_line_q   <= PW'(1);
      cur_col_q    <= PW'(1);
      prefix_q     <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mode_q     <= mode_d;
        seen_q     <= seen_d;
        tok_line_q <= tok_line_d;
        tok_col_q  <= tok_col_d;
        tok_len_q  <= tok_len_d;
        cur_line_q <= cur_line_d;
        cur_col_q  <= cur_col_d;
        prefix_q   <= prefix_d;
        pend_q     <= pend_d;
      end
      if (adv) begin
        if (hold_valid_q) begin
          out_valid_q  <= 1'b1;
          hold_valid_q <= 1'b0;
        end else if (fire) begin
          out_valid_q  <= flush_go || sec_v;
          hold_valid_q <= flush_go && sec_v;
        end else begin
          out_valid_q  <= 1'b0;
        end
      end
    end
  end

  // payload side of the output register and the second-result hold slot
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (hold_valid_q) begin
        out_q <= hold_q;
      end else if (fire) begin
        out_q  <= flush_go ? first_r : sec_r;
        hold_q <= sec_r;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign stat_o.hold_valid = hold_valid_q;
  assign stat_o.item_taken = fire;

endmodule

>>> src/c_subset_token_scanner_unit.sv
// top level of the c-subset token scanner: front end, transaction queue, back end
// depends on cts_pkg, cts_front, cts_queue, cts_back
// path: an accepted character is written into the queue, and its result is then
//   registered in the back end output register before it is shown
// throughput: one character per cycle while the output is taken; a character that ends
//   a token and is itself a token or eof holds the back end for its second result
// reset: asynchronous; line and column return to 1 and the scanner to idle, queue empties
module c_subset_token_scanner_unit import cts_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault,
  parameter int unsigned LENGTH_WIDTH   = LengthWidthDefault,
  parameter int unsigned QUEUE_DEPTH    = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cts_out_t out_data_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  cts_entry_t     push_data, pop_data;
  cts_back_stat_t back_stat;

  cts_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cts_back #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LENGTH_WIDTH   (LENGTH_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (back_stat)
  );

  // a waiting second result always sits behind a first one that is not last
  a_hold_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.hold_valid |-> (out_valid_o && !out_data_o.last))
    else $error("second result held without a non-last first result");

  a_not_last_has_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> back_stat.hold_valid)
    else $error("non-last result shown with no second result held");

  a_no_pop_while_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.hold_valid |-> !back_stat.item_taken)
    else $error("back end took a transaction while a result was held");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> pop_valid)
    else $error("accepted transaction missing from queue");

endmodule
